/* hw/rtl/hmbp_pkg.sv */
package hmbp_pkg;

    typedef enum logic [4:0] {
        P_MSG, P_LEAD, P_T1, P_T1SP, P_T2, P_T2SP, P_T3, P_L1LF, P_HDR, P_NAME, P_VAL,
        P_VALLF, P_LWS, P_ENDH, P_IBODY, P_CSIZE, P_CEXT, P_CSLF, P_CHUNK, P_CCR, P_CLF,
        P_THDR, P_TNAME, P_TVAL, P_TVALLF, P_TLWS, P_FINLF
    } phase_t;

    typedef struct packed {
        logic       is_sp;
        logic       is_text;
        logic       is_ctl;
        logic       is_tok;
        logic       is_hex;
        logic [3:0] hex_val;
        logic [7:0] lower;
    } char_class_t;

    localparam logic [2:0] ROLE_DELIM  = 3'd0;
    localparam logic [2:0] ROLE_FIRST  = 3'd1;
    localparam logic [2:0] ROLE_SECOND = 3'd2;
    localparam logic [2:0] ROLE_THIRD  = 3'd3;
    localparam logic [2:0] ROLE_NAME   = 3'd4;
    localparam logic [2:0] ROLE_VALUE  = 3'd5;
    localparam logic [2:0] ROLE_BODY   = 3'd6;

    localparam logic [4:0] ERR_T1_INVALID    = 5'd0;
    localparam logic [4:0] ERR_T1_LONG       = 5'd1;
    localparam logic [4:0] ERR_T2_INVALID    = 5'd2;
    localparam logic [4:0] ERR_T2_LONG       = 5'd3;
    localparam logic [4:0] ERR_T3_INVALID    = 5'd4;
    localparam logic [4:0] ERR_T3_LONG       = 5'd5;
    localparam logic [4:0] ERR_L1_LF         = 5'd6;
    localparam logic [4:0] ERR_HDR_COUNT     = 5'd7;
    localparam logic [4:0] ERR_NAME_EMPTY    = 5'd8;
    localparam logic [4:0] ERR_NAME_INVALID  = 5'd9;
    localparam logic [4:0] ERR_NAME_LONG     = 5'd10;
    localparam logic [4:0] ERR_NO_COLON      = 5'd11;
    localparam logic [4:0] ERR_VALUE_INVALID = 5'd12;
    localparam logic [4:0] ERR_VALUE_LONG    = 5'd13;
    localparam logic [4:0] ERR_HDR_LF        = 5'd14;
    localparam logic [4:0] ERR_CLEN_INVALID  = 5'd15;
    localparam logic [4:0] ERR_CSIZE_EMPTY   = 5'd16;
    localparam logic [4:0] ERR_CSIZE_INVALID = 5'd17;
    localparam logic [4:0] ERR_CSIZE_LF      = 5'd18;
    localparam logic [4:0] ERR_CDATA_CR      = 5'd19;
    localparam logic [4:0] ERR_CDATA_LF      = 5'd20;
    localparam logic [4:0] ERR_FINAL_LF      = 5'd21;

    localparam logic [2:0] REG_FIRST_LIMIT  = 3'd0;
    localparam logic [2:0] REG_SECOND_LIMIT = 3'd1;
    localparam logic [2:0] REG_THIRD_LIMIT  = 3'd2;
    localparam logic [2:0] REG_NAME_LIMIT   = 3'd3;
    localparam logic [2:0] REG_VALUE_LIMIT  = 3'd4;
    localparam logic [2:0] REG_COUNT_LIMIT  = 3'd5;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COLON = 8'd58;

    localparam int TE_LEN = 17;
    localparam int CL_LEN = 14;
    localparam int CHUNKED_LEN = 7;

    // Lower-case spelling of the header names and the chunked keyword.
    function automatic logic [7:0] te_char(input logic [4:0] idx);
        logic [7:0] ch;
        unique case (idx)
            5'd0:  ch = "t";
            5'd1:  ch = "r";
            5'd2:  ch = "a";
            5'd3:  ch = "n";
            5'd4:  ch = "s";
            5'd5:  ch = "f";
            5'd6:  ch = "e";
            5'd7:  ch = "r";
            5'd8:  ch = "-";
            5'd9:  ch = "e";
            5'd10: ch = "n";
            5'd11: ch = "c";
            5'd12: ch = "o";
            5'd13: ch = "d";
            5'd14: ch = "i";
            5'd15: ch = "n";
            5'd16: ch = "g";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] cl_char(input logic [4:0] idx);
        logic [7:0] ch;
        unique case (idx)
            5'd0:  ch = "c";
            5'd1:  ch = "o";
            5'd2:  ch = "n";
            5'd3:  ch = "t";
            5'd4:  ch = "e";
            5'd5:  ch = "n";
            5'd6:  ch = "t";
            5'd7:  ch = "-";
            5'd8:  ch = "l";
            5'd9:  ch = "e";
            5'd10: ch = "n";
            5'd11: ch = "g";
            5'd12: ch = "t";
            5'd13: ch = "h";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] chunked_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0: ch = "c";
            4'd1: ch = "h";
            4'd2: ch = "u";
            4'd3: ch = "n";
            4'd4: ch = "k";
            4'd5: ch = "e";
            4'd6: ch = "d";
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

/* hw/rtl/hmbp_char_class.sv */
module hmbp_char_class (
    input  logic [7:0]                 data_byte,
    output hmbp_pkg::char_class_t      char_class
);

    logic is_sep;

    always_comb begin
        unique case (data_byte)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "=", "{", "}":
                is_sep = 1'b1;
            default:
                is_sep = 1'b0;
        endcase
    end

    always_comb begin
        char_class.is_sp   = (data_byte == hmbp_pkg::CH_SPACE) || (data_byte == hmbp_pkg::CH_TAB);
        char_class.is_text = (data_byte >= 8'd32) && (data_byte <= 8'd126);
        char_class.is_ctl  = (data_byte < 8'd32) || (data_byte == 8'd127);
        char_class.is_tok  = (data_byte >= 8'd33) && (data_byte <= 8'd126)
                             && (data_byte != 8'd63) && !is_sep;
        char_class.lower   = ((data_byte >= 8'd65) && (data_byte <= 8'd90))
                             ? data_byte + 8'd32 : data_byte;
        char_class.is_hex  = 1'b0;
        char_class.hex_val = 4'd0;
        if ((data_byte >= 8'd48) && (data_byte <= 8'd57)) begin
            char_class.is_hex  = 1'b1;
            char_class.hex_val = 4'(data_byte - 8'd48);
        end else if ((char_class.lower >= 8'd97) && (char_class.lower <= 8'd102)) begin
            char_class.is_hex  = 1'b1;
            char_class.hex_val = 4'(char_class.lower - 8'd87);
        end
    end

endmodule

/* hw/rtl/http_message_byte_parser_top.sv */
// Checks an HTTP/1.1 byte stream one byte per word and tags every byte with its role (start-line
// token, header name, header value, body or framing), flagging message ends and errors with the
// byte offset, line and column. A byte sits in the input register; the parse logic updates the
// state and writes the result register once the output side has taken the previous word, so
// the throughput is one byte per cycle as long as the output side keeps taking words. A rejected
// byte leaves the parser state as it was. Length limits and the header count limit are written
// through the cfg port while idle.
module http_message_byte_parser_top #(
    parameter int COUNT_WIDTH  = 32,
    parameter int LENGTH_WIDTH = 13
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_byte_echo,
    output logic [2:0]  m_byte_role,
    output logic        m_message_done,
    output logic        m_parse_error,
    output logic [4:0]  m_error_code,
    output logic [31:0] m_error_position,
    output logic [31:0] m_error_line,
    output logic [31:0] m_error_column,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int CW = COUNT_WIDTH;
    localparam int LW = LENGTH_WIDTH;

    // Limits.
    logic [12:0] first_limit_reg, second_limit_reg, third_limit_reg;
    logic [12:0] name_limit_reg, value_limit_reg;
    logic [7:0]  count_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_limit_reg  <= 13'd16;
            second_limit_reg <= 13'd2048;
            third_limit_reg  <= 13'd16;
            name_limit_reg   <= 13'd256;
            value_limit_reg  <= 13'd4096;
            count_limit_reg  <= 8'd64;
        end else if (cfg_we) begin
            unique case (cfg_index)
                hmbp_pkg::REG_FIRST_LIMIT:  first_limit_reg  <= cfg_data;
                hmbp_pkg::REG_SECOND_LIMIT: second_limit_reg <= cfg_data;
                hmbp_pkg::REG_THIRD_LIMIT:  third_limit_reg  <= cfg_data;
                hmbp_pkg::REG_NAME_LIMIT:   name_limit_reg   <= cfg_data;
                hmbp_pkg::REG_VALUE_LIMIT:  value_limit_reg  <= cfg_data;
                hmbp_pkg::REG_COUNT_LIMIT:  count_limit_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Input register and handshake.
    logic       in_valid_reg;
    logic [7:0] data_reg;
    logic       advance;

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_data_byte;
        end
    end

    hmbp_pkg::char_class_t cc;

    hmbp_char_class u_char_class (
        .data_byte  (data_reg),
        .char_class (cc)
    );

    // Parser state.
    hmbp_pkg::phase_t phase_reg, phase_next;
    logic [LW-1:0] tok_reg, tok_next;
    logic [LW-1:0] val_reg, val_next;
    logic [7:0]    hc_reg, hc_next;
    logic [1:0]    flags_reg, flags_next;
    logic [3:0]    vms_reg, vms_next;
    logic          chunked_reg, chunked_next;
    logic          lseen_reg, lseen_next;
    logic          linv_reg, linv_next;
    logic [CW-1:0] clen_reg, clen_next;
    logic [CW-1:0] bc_reg, bc_next;
    logic [CW-1:0] cs_reg, cs_next;
    logic [3:0]    cdc_reg, cdc_next;
    logic [CW-1:0] cc_reg, cc_next;
    logic [CW-1:0] off_reg, off_next;
    logic [CW-1:0] line_reg, line_next;
    logic [CW-1:0] col_reg, col_next;

    logic          err;
    logic [4:0]    err_code;
    logic [2:0]    role;
    logic          trailer;
    logic          do_name, do_value, do_append;
    logic [7:0]    vc;
    logic [CW+3:0] clen_prod;
    logic [LW-1:0] tok_sat;
    logic [15:0]   tok_w, val_w;
    logic          app_full;
    hmbp_pkg::phase_t base_ph, end_ph;

    assign tok_w    = 16'(tok_reg);
    assign val_w    = 16'(val_reg);
    assign app_full = hc_reg >= count_limit_reg;

    always_comb begin
        phase_next   = phase_reg;
        tok_next     = tok_reg;
        val_next     = val_reg;
        hc_next      = hc_reg;
        flags_next   = flags_reg;
        vms_next     = vms_reg;
        chunked_next = chunked_reg;
        lseen_next   = lseen_reg;
        linv_next    = linv_reg;
        clen_next    = clen_reg;
        bc_next      = bc_reg;
        cs_next      = cs_reg;
        cdc_next     = cdc_reg;
        cc_next      = cc_reg;
        off_next     = off_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        err          = 1'b0;
        err_code     = hmbp_pkg::ERR_T1_INVALID;
        do_name      = 1'b0;
        do_value     = 1'b0;
        do_append    = 1'b0;
        vc           = cc.lower;
        clen_prod    = '0;
        tok_sat      = '0;
        role         = ((phase_reg == hmbp_pkg::P_IBODY) || (phase_reg == hmbp_pkg::P_CHUNK))
                       ? hmbp_pkg::ROLE_BODY : hmbp_pkg::ROLE_DELIM;
        trailer      = (phase_reg >= hmbp_pkg::P_THDR) && (phase_reg <= hmbp_pkg::P_TLWS);
        base_ph      = trailer ? hmbp_pkg::P_THDR : hmbp_pkg::P_HDR;
        end_ph       = trailer ? hmbp_pkg::P_FINLF : hmbp_pkg::P_ENDH;

        unique case (phase_reg)
            hmbp_pkg::P_LEAD, hmbp_pkg::P_T1SP, hmbp_pkg::P_T2SP: begin
                if (cc.is_sp) begin
                end else if (!cc.is_text) begin
                    err = 1'b1;
                    err_code = (phase_reg == hmbp_pkg::P_LEAD) ? hmbp_pkg::ERR_T1_INVALID :
                               (phase_reg == hmbp_pkg::P_T1SP) ? hmbp_pkg::ERR_T2_INVALID :
                                                                 hmbp_pkg::ERR_T3_INVALID;
                end else begin
                    tok_next = LW'(1);
                    phase_next = hmbp_pkg::phase_t'(phase_reg + 5'd1);
                    role = (phase_reg == hmbp_pkg::P_LEAD) ? hmbp_pkg::ROLE_FIRST :
                           (phase_reg == hmbp_pkg::P_T1SP) ? hmbp_pkg::ROLE_SECOND :
                                                             hmbp_pkg::ROLE_THIRD;
                end
            end
            hmbp_pkg::P_T1, hmbp_pkg::P_T2: begin
                if (cc.is_sp) begin
                    phase_next = hmbp_pkg::phase_t'(phase_reg + 5'd1);
                end else if (!cc.is_text) begin
                    err = 1'b1;
                    err_code = (phase_reg == hmbp_pkg::P_T1) ? hmbp_pkg::ERR_T1_INVALID
                                                             : hmbp_pkg::ERR_T2_INVALID;
                end else if ((phase_reg == hmbp_pkg::P_T1) && (tok_w >= 16'(first_limit_reg))) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_T1_LONG;
                end else if ((phase_reg == hmbp_pkg::P_T2) && (tok_w >= 16'(second_limit_reg))) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_T2_LONG;
                end else begin
                    tok_next = (tok_reg != '1) ? tok_reg + LW'(1) : tok_reg;
                    role = (phase_reg == hmbp_pkg::P_T1) ? hmbp_pkg::ROLE_FIRST
                                                         : hmbp_pkg::ROLE_SECOND;
                end
            end
            hmbp_pkg::P_T3: begin
                if (data_reg == hmbp_pkg::CH_CR) begin
                    phase_next = hmbp_pkg::P_L1LF;
                end else if (!cc.is_text) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_T3_INVALID;
                end else if (tok_w >= 16'(third_limit_reg)) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_T3_LONG;
                end else begin
                    tok_next = (tok_reg != '1) ? tok_reg + LW'(1) : tok_reg;
                    role = hmbp_pkg::ROLE_THIRD;
                end
            end
            hmbp_pkg::P_L1LF: begin
                if (data_reg != hmbp_pkg::CH_LF) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_L1_LF;
                end else begin
                    phase_next = hmbp_pkg::P_HDR;
                end
            end
            hmbp_pkg::P_HDR, hmbp_pkg::P_THDR: begin
                tok_next = '0;
                val_next = '0;
                if (data_reg == hmbp_pkg::CH_CR) begin
                    phase_next = end_ph;
                end else if (data_reg == hmbp_pkg::CH_COLON) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_NAME_EMPTY;
                end else if (!cc.is_tok) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_NAME_INVALID;
                end else begin
                    flags_next = 2'b11;
                    do_name = 1'b1;
                    phase_next = hmbp_pkg::phase_t'(base_ph + 5'd1);
                    role = hmbp_pkg::ROLE_NAME;
                end
            end
            hmbp_pkg::P_NAME, hmbp_pkg::P_TNAME: begin
                if (data_reg == hmbp_pkg::CH_CR) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_NO_COLON;
                end else if (data_reg == hmbp_pkg::CH_COLON) begin
                    if (tok_w != 16'(hmbp_pkg::TE_LEN)) flags_next[0] = 1'b0;
                    if (tok_w != 16'(hmbp_pkg::CL_LEN)) flags_next[1] = 1'b0;
                    val_next = '0;
                    vms_next = 4'd0;
                    phase_next = hmbp_pkg::phase_t'(base_ph + 5'd2);
                end else if (!cc.is_tok) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_NAME_INVALID;
                end else if (tok_w >= 16'(name_limit_reg)) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_NAME_LONG;
                end else begin
                    do_name = 1'b1;
                    role = hmbp_pkg::ROLE_NAME;
                end
            end
            hmbp_pkg::P_VAL, hmbp_pkg::P_TVAL: begin
                if (data_reg == hmbp_pkg::CH_CR) begin
                    phase_next = hmbp_pkg::phase_t'(base_ph + 5'd3);
                end else if (cc.is_ctl) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_VALUE_INVALID;
                end else if (val_w >= 16'(value_limit_reg)) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_VALUE_LONG;
                end else begin
                    do_value = 1'b1;
                    role = hmbp_pkg::ROLE_VALUE;
                end
            end
            hmbp_pkg::P_VALLF, hmbp_pkg::P_TVALLF: begin
                if (data_reg != hmbp_pkg::CH_LF) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_HDR_LF;
                end else begin
                    phase_next = hmbp_pkg::phase_t'(base_ph + 5'd4);
                end
            end
            hmbp_pkg::P_LWS, hmbp_pkg::P_TLWS: begin
                if (data_reg == hmbp_pkg::CH_CR) begin
                    if (app_full) begin
                        err = 1'b1;
                        err_code = hmbp_pkg::ERR_HDR_COUNT;
                    end else begin
                        do_append = 1'b1;
                        phase_next = end_ph;
                    end
                end else if (data_reg == hmbp_pkg::CH_COLON) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_NAME_EMPTY;
                end else if (cc.is_sp) begin
                    // A fold joins the value as a single space.
                    if (val_w >= 16'(value_limit_reg)) begin
                        err = 1'b1;
                        err_code = hmbp_pkg::ERR_VALUE_LONG;
                    end else begin
                        vc = hmbp_pkg::CH_SPACE;
                        do_value = 1'b1;
                        phase_next = hmbp_pkg::phase_t'(base_ph + 5'd2);
                        role = hmbp_pkg::ROLE_VALUE;
                    end
                end else if (!cc.is_tok) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_NAME_INVALID;
                end else if (app_full) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_HDR_COUNT;
                end else begin
                    do_append = 1'b1;
                    flags_next = 2'b11;
                    tok_next = '0;
                    do_name = 1'b1;
                    phase_next = hmbp_pkg::phase_t'(base_ph + 5'd1);
                    role = hmbp_pkg::ROLE_NAME;
                end
            end
            hmbp_pkg::P_ENDH: begin
                if (data_reg != hmbp_pkg::CH_LF) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_HDR_LF;
                end else if (chunked_reg) begin
                    cs_next = '0;
                    cdc_next = 4'd0;
                    phase_next = hmbp_pkg::P_CSIZE;
                end else if (lseen_reg) begin
                    if (linv_reg) begin
                        err = 1'b1;
                        err_code = hmbp_pkg::ERR_CLEN_INVALID;
                    end else begin
                        phase_next = (clen_reg == '0) ? hmbp_pkg::P_MSG : hmbp_pkg::P_IBODY;
                    end
                end else begin
                    phase_next = hmbp_pkg::P_MSG;
                end
            end
            hmbp_pkg::P_IBODY: begin
                bc_next = (bc_reg != '1) ? bc_reg + CW'(1) : bc_reg;
                if (bc_next >= clen_reg) phase_next = hmbp_pkg::P_MSG;
            end
            hmbp_pkg::P_CSIZE: begin
                if (cc.is_hex) begin
                    if (cdc_reg == 4'd15) begin
                    end else if (cs_reg[CW-1 -: 4] != 4'd0) begin
                        cdc_next = 4'd15;
                    end else begin
                        cs_next = {cs_reg[CW-5:0], cc.hex_val};
                        if (cdc_reg < 4'd14) cdc_next = cdc_reg + 4'd1;
                    end
                end else if (cdc_reg == 4'd0) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_CSIZE_EMPTY;
                end else if (cdc_reg == 4'd15) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_CSIZE_INVALID;
                end else begin
                    cc_next = '0;
                    cdc_next = 4'd0;
                    phase_next = (data_reg == hmbp_pkg::CH_CR) ? hmbp_pkg::P_CSLF
                                                               : hmbp_pkg::P_CEXT;
                end
            end
            hmbp_pkg::P_CEXT: begin
                if (data_reg == hmbp_pkg::CH_CR) phase_next = hmbp_pkg::P_CSLF;
            end
            hmbp_pkg::P_CSLF: begin
                if (data_reg != hmbp_pkg::CH_LF) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_CSIZE_LF;
                end else begin
                    phase_next = (cs_reg != '0) ? hmbp_pkg::P_CHUNK : hmbp_pkg::P_THDR;
                end
            end
            hmbp_pkg::P_CHUNK: begin
                cc_next = (cc_reg != '1) ? cc_reg + CW'(1) : cc_reg;
                if (cc_next >= cs_reg) phase_next = hmbp_pkg::P_CCR;
            end
            hmbp_pkg::P_CCR: begin
                if (data_reg != hmbp_pkg::CH_CR) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_CDATA_CR;
                end else begin
                    phase_next = hmbp_pkg::P_CLF;
                end
            end
            hmbp_pkg::P_CLF: begin
                if (data_reg != hmbp_pkg::CH_LF) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_CDATA_LF;
                end else begin
                    cs_next = '0;
                    phase_next = hmbp_pkg::P_CSIZE;
                end
            end
            hmbp_pkg::P_FINLF: begin
                if (data_reg != hmbp_pkg::CH_LF) begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_FINAL_LF;
                end else begin
                    phase_next = hmbp_pkg::P_MSG;
                end
            end
            default: begin
                // Message start; the first byte clears everything left by the last message.
                if (cc.is_sp || cc.is_text) begin
                    tok_next     = cc.is_sp ? '0 : LW'(1);
                    val_next     = '0;
                    hc_next      = 8'd0;
                    flags_next   = 2'b11;
                    vms_next     = 4'd0;
                    chunked_next = 1'b0;
                    lseen_next   = 1'b0;
                    linv_next    = 1'b0;
                    clen_next    = '0;
                    bc_next      = '0;
                    cs_next      = '0;
                    cdc_next     = 4'd0;
                    cc_next      = '0;
                    off_next     = '0;
                    line_next    = CW'(1);
                    col_next     = CW'(1);
                    phase_next   = cc.is_sp ? hmbp_pkg::P_LEAD : hmbp_pkg::P_T1;
                    role         = cc.is_sp ? hmbp_pkg::ROLE_DELIM : hmbp_pkg::ROLE_FIRST;
                end else begin
                    err = 1'b1;
                    err_code = hmbp_pkg::ERR_T1_INVALID;
                end
            end
        endcase

        // Closing a header: note chunked framing and the first Content-Length.
        if (do_append) begin
            hc_next = hc_reg + 8'd1;
            if (!trailer) begin
                if (flags_reg[0] && ((vms_reg == 4'd7) || (vms_reg == 4'd8))) chunked_next = 1'b1;
                if (flags_reg[1] && !lseen_reg) begin
                    lseen_next = 1'b1;
                    linv_next  = !((vms_reg == 4'd1) || (vms_reg == 4'd2));
                end
            end
        end

        if (do_name) begin
            if (!((tok_next < LW'(hmbp_pkg::TE_LEN))
                  && (cc.lower == hmbp_pkg::te_char(tok_next[4:0])))) flags_next[0] = 1'b0;
            if (!((tok_next < LW'(hmbp_pkg::CL_LEN))
                  && (cc.lower == hmbp_pkg::cl_char(tok_next[4:0])))) flags_next[1] = 1'b0;
            tok_sat  = tok_next;
            tok_next = (tok_sat != '1) ? tok_sat + LW'(1) : tok_sat;
        end

        if (do_value) begin
            val_next = (val_reg != '1) ? val_reg + LW'(1) : val_reg;
            if (!trailer && (vms_reg != 4'd15)) begin
                if (flags_reg[0]) begin
                    if (vc == hmbp_pkg::CH_SPACE) begin
                        vms_next = (vms_reg == 4'd0) ? 4'd0 : ((vms_reg >= 4'd7) ? 4'd8 : 4'd15);
                    end else if ((vms_reg < 4'd7) && (vc == hmbp_pkg::chunked_char(vms_reg))) begin
                        vms_next = vms_reg + 4'd1;
                    end else begin
                        vms_next = 4'd15;
                    end
                end else if (flags_reg[1]) begin
                    if ((vc >= 8'd48) && (vc <= 8'd57)) begin
                        if (vms_reg == 4'd2) begin
                            vms_next = 4'd15;
                        end else begin
                            vms_next = 4'd1;
                            if (!lseen_reg) begin
                                clen_prod = {1'b0, clen_reg, 3'b000} + {3'b000, clen_reg, 1'b0}
                                            + (CW+4)'(vc - 8'd48);
                                if (clen_prod[CW+3:CW] != 4'd0) vms_next = 4'd15;
                                else clen_next = clen_prod[CW-1:0];
                            end
                        end
                    end else if (vc == hmbp_pkg::CH_SPACE) begin
                        vms_next = (vms_reg == 4'd0) ? 4'd0 : 4'd2;
                    end else begin
                        vms_next = 4'd15;
                    end
                end
            end
        end

        off_next = off_next + CW'(1);
        if (data_reg == hmbp_pkg::CH_LF) begin
            line_next = line_next + CW'(1);
            col_next  = CW'(1);
        end else begin
            col_next  = col_next + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= hmbp_pkg::P_MSG;
            tok_reg     <= '0;
            val_reg     <= '0;
            hc_reg      <= 8'd0;
            flags_reg   <= 2'b11;
            vms_reg     <= 4'd0;
            chunked_reg <= 1'b0;
            lseen_reg   <= 1'b0;
            linv_reg    <= 1'b0;
            clen_reg    <= '0;
            bc_reg      <= '0;
            cs_reg      <= '0;
            cdc_reg     <= 4'd0;
            cc_reg      <= '0;
            off_reg     <= '0;
            line_reg    <= CW'(1);
            col_reg     <= CW'(1);
        end else if (advance && !err) begin
            phase_reg   <= phase_next;
            tok_reg     <= tok_next;
            val_reg     <= val_next;
            hc_reg      <= hc_next;
            flags_reg   <= flags_next;
            vms_reg     <= vms_next;
            chunked_reg <= chunked_next;
            lseen_reg   <= lseen_next;
            linv_reg    <= linv_next;
            clen_reg    <= clen_next;
            bc_reg      <= bc_next;
            cs_reg      <= cs_next;
            cdc_reg     <= cdc_next;
            cc_reg      <= cc_next;
            off_reg     <= off_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
        end
    end

    // Result register.
    logic [63:0] off_ext, line_ext, col_ext;

    assign off_ext  = 64'(off_reg);
    assign line_ext = 64'(line_reg);
    assign col_ext  = 64'(col_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (advance) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_byte_echo   <= data_reg;
            m_parse_error <= err;
            if (err) begin
                m_byte_role      <= hmbp_pkg::ROLE_DELIM;
                m_message_done   <= (phase_reg == hmbp_pkg::P_MSG);
                m_error_code     <= err_code;
                m_error_position <= off_ext[31:0];
                m_error_line     <= line_ext[31:0];
                m_error_column   <= col_ext[31:0];
            end else begin
                m_byte_role      <= role;
                m_message_done   <= (phase_next == hmbp_pkg::P_MSG);
                m_error_code     <= 5'd0;
                m_error_position <= 32'd0;
                m_error_line     <= 32'd0;
                m_error_column   <= 32'd0;
            end
        end
    end

endmodule

/* bench/http_byte_checker.sv */
`timescale 1ns / 1ps
module http_byte_checker
    import hmbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_byte_echo,
    input  logic [2:0]  m_byte_role,
    input  logic        m_message_done,
    input  logic        m_parse_error,
    input  logic [4:0]  m_error_code,
    input  logic [31:0] m_error_position,
    input  logic [31:0] m_error_line,
    input  logic [31:0] m_error_column,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    output int          error_count,
    output int          pending
);

    localparam longint unsigned COUNT_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam int unsigned LEN_MAX = 8191;

    typedef struct packed {
        logic [7:0]  echo;
        logic [2:0]  role;
        logic        done;
        logic        perr;
        logic [4:0]  code;
        logic [31:0] pos;
        logic [31:0] line;
        logic [31:0] col;
    } byte_result_t;

    typedef struct {
        phase_t          ph;
        int unsigned     tlen, vlen, hcnt;
        logic [1:0]      nm;
        int unsigned     vms;
        bit              chk, lseen, linv;
        longint unsigned clen, bcnt, csize;
        int unsigned     cdig;
        longint unsigned ccnt, off, lno, col;
    } parse_state_t;

    string te_word = "transfer-encoding";
    string cl_word = "content-length";
    string ck_word = "chunked";

    parse_state_t ps;
    int unsigned  lim [6];
    byte_result_t expected_results [$];
    int           fails;

    function automatic parse_state_t fresh_state();
        parse_state_t s;
        s = '{P_MSG, 0, 0, 0, 2'b11, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1};
        return s;
    endfunction

    function automatic bit is_sp(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic bit is_text(logic [7:0] c);
        return c >= 8'd32 && c <= 8'd126;
    endfunction

    function automatic bit is_ctl(logic [7:0] c);
        return c < 8'd32 || c == 8'd127;
    endfunction

    function automatic logic [7:0] lower(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic bit is_tok(logic [7:0] c);
        if (c < 8'd33 || c > 8'd126 || c == "?")
            return 0;
        case (c)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "=", "{", "}":
                return 0;
            default: return 1;
        endcase
    endfunction

    function automatic int hex_of(logic [7:0] c);
        logic [7:0] l;
        l = lower(c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (l >= "a" && l <= "f") return int'(l) - 87;
        return -1;
    endfunction

    function automatic int unsigned len_inc(int unsigned v);
        return v < LEN_MAX ? v + 1 : v;
    endfunction

    function automatic void name_char(inout parse_state_t s, input logic [7:0] c);
        int unsigned i;
        i = s.tlen;
        if (!(i < 17 && lower(c) == te_word[i])) s.nm[0] = 1'b0;
        if (!(i < 14 && lower(c) == cl_word[i])) s.nm[1] = 1'b0;
        s.tlen = len_inc(s.tlen);
    endfunction

    function automatic void start_name(inout parse_state_t s, input logic [7:0] c);
        s.nm = 2'b11;
        s.tlen = 0;
        name_char(s, c);
    endfunction

    // Tracks whether the value still spells "chunked" or a decimal length.
    function automatic void value_char(inout parse_state_t s, input logic [7:0] c, input bit tr);
        int unsigned st;
        longint unsigned d;
        st = s.vms;
        s.vlen = len_inc(s.vlen);
        if (tr || st == 15) return;
        if (s.nm[0]) begin
            if (c == CH_SPACE) st = (st == 0) ? 0 : (st >= 7 ? 8 : 15);
            else if (st < 7 && lower(c) == ck_word[st]) st++;
            else st = 15;
        end else if (s.nm[1]) begin
            if (c >= "0" && c <= "9") begin
                if (st == 2) st = 15;
                else begin
                    d = c - 8'd48;
                    st = 1;
                    if (!s.lseen) begin
                        if (s.clen > (COUNT_MAX - d) / 10) st = 15;
                        else s.clen = s.clen * 10 + d;
                    end
                end
            end else if (c == CH_SPACE) st = (st == 0) ? 0 : 2;
            else st = 15;
        end
        s.vms = st;
    endfunction

    function automatic int append_hdr(inout parse_state_t s, input bit tr);
        if (s.hcnt >= lim[5]) return ERR_HDR_COUNT;
        s.hcnt++;
        if (!tr) begin
            if (s.nm[0] && (s.vms == 7 || s.vms == 8)) s.chk = 1;
            if (s.nm[1] && !s.lseen) begin
                s.lseen = 1;
                s.linv = !(s.vms == 1 || s.vms == 2);
            end
        end
        return -1;
    endfunction

    function automatic int header_step(inout parse_state_t s, input logic [7:0] c,
                                       input int off, input bit tr, inout logic [2:0] role);
        phase_t base, endp;
        int e;
        base = tr ? P_THDR : P_HDR;
        endp = tr ? P_FINLF : P_ENDH;
        case (off)
            0: begin
                s.tlen = 0;
                s.vlen = 0;
                if (c == CH_CR) begin
                    s.ph = endp;
                    return -1;
                end
                if (c == CH_COLON) return ERR_NAME_EMPTY;
                if (!is_tok(c)) return ERR_NAME_INVALID;
                start_name(s, c);
                s.ph = phase_t'(base + 1);
                role = ROLE_NAME;
                return -1;
            end
            1: begin
                if (c == CH_CR) return ERR_NO_COLON;
                if (c == CH_COLON) begin
                    if (s.tlen != 17) s.nm[0] = 1'b0;
                    if (s.tlen != 14) s.nm[1] = 1'b0;
                    s.vlen = 0;
                    s.vms = 0;
                    s.ph = phase_t'(base + 2);
                    return -1;
                end
                if (!is_tok(c)) return ERR_NAME_INVALID;
                if (s.tlen >= lim[3]) return ERR_NAME_LONG;
                name_char(s, c);
                role = ROLE_NAME;
                return -1;
            end
            2: begin
                if (c == CH_CR) begin
                    s.ph = phase_t'(base + 3);
                    return -1;
                end
                if (is_ctl(c)) return ERR_VALUE_INVALID;
                if (s.vlen >= lim[4]) return ERR_VALUE_LONG;
                value_char(s, c, tr);
                role = ROLE_VALUE;
                return -1;
            end
            3: begin
                if (c != CH_LF) return ERR_HDR_LF;
                s.ph = phase_t'(base + 4);
                return -1;
            end
            default: begin
                // Line after a header: blank line, fold, or the next name.
                if (c == CH_CR) begin
                    e = append_hdr(s, tr);
                    if (e >= 0) return e;
                    s.ph = endp;
                    return -1;
                end
                if (c == CH_COLON) return ERR_NAME_EMPTY;
                if (is_sp(c)) begin
                    if (s.vlen >= lim[4]) return ERR_VALUE_LONG;
                    value_char(s, CH_SPACE, tr);
                    s.ph = phase_t'(base + 2);
                    role = ROLE_VALUE;
                    return -1;
                end
                if (!is_tok(c)) return ERR_NAME_INVALID;
                e = append_hdr(s, tr);
                if (e >= 0) return e;
                start_name(s, c);
                s.ph = phase_t'(base + 1);
                role = ROLE_NAME;
                return -1;
            end
        endcase
    endfunction

    function automatic int body_step(inout parse_state_t s, input logic [7:0] c);
        int h;
        case (s.ph)
            P_ENDH: begin
                if (c != CH_LF) return ERR_HDR_LF;
                if (s.chk) begin
                    s.csize = 0;
                    s.cdig = 0;
                    s.ph = P_CSIZE;
                end else if (s.lseen) begin
                    if (s.linv) return ERR_CLEN_INVALID;
                    s.ph = (s.clen == 0) ? P_MSG : P_IBODY;
                end else s.ph = P_MSG;
                return -1;
            end
            P_IBODY: begin
                if (s.bcnt < COUNT_MAX) s.bcnt++;
                if (s.bcnt >= s.clen) s.ph = P_MSG;
                return -1;
            end
            P_CSIZE: begin
                h = hex_of(c);
                if (h >= 0) begin
                    if (s.cdig == 15) return -1;
                    if (s.csize > (COUNT_MAX >> 4)) begin
                        s.cdig = 15;
                        return -1;
                    end
                    s.csize = (s.csize << 4) | longint'(h);
                    if (s.cdig < 14) s.cdig++;
                    return -1;
                end
                if (s.cdig == 0) return ERR_CSIZE_EMPTY;
                if (s.cdig == 15) return ERR_CSIZE_INVALID;
                s.ccnt = 0;
                s.cdig = 0;
                s.ph = (c == CH_CR) ? P_CSLF : P_CEXT;
                return -1;
            end
            P_CEXT: begin
                if (c == CH_CR) s.ph = P_CSLF;
                return -1;
            end
            P_CSLF: begin
                if (c != CH_LF) return ERR_CSIZE_LF;
                s.ph = (s.csize > 0) ? P_CHUNK : P_THDR;
                return -1;
            end
            P_CHUNK: begin
                if (s.ccnt < COUNT_MAX) s.ccnt++;
                if (s.ccnt >= s.csize) s.ph = P_CCR;
                return -1;
            end
            P_CCR: begin
                if (c != CH_CR) return ERR_CDATA_CR;
                s.ph = P_CLF;
                return -1;
            end
            P_CLF: begin
                if (c != CH_LF) return ERR_CDATA_LF;
                s.csize = 0;
                s.ph = P_CSIZE;
                return -1;
            end
            default: begin
                if (c != CH_LF) return ERR_FINAL_LF;
                s.ph = P_MSG;
                return -1;
            end
        endcase
    endfunction

    function automatic int token_char(inout parse_state_t s, input int unsigned limit,
                                      input int code);
        if (s.tlen >= limit) return code;
        s.tlen = len_inc(s.tlen);
        return -1;
    endfunction

    function automatic byte_result_t predict_byte(input logic [7:0] c);
        parse_state_t n;
        logic [2:0] role;
        phase_t ph;
        int err;
        byte_result_t r;
        n = ps;
        role = ROLE_DELIM;
        ph = n.ph;
        err = -1;
        if (ph == P_IBODY || ph == P_CHUNK) role = ROLE_BODY;
        case (ph)
            P_LEAD, P_T1SP, P_T2SP: begin
                if (!is_sp(c)) begin
                    if (!is_text(c))
                        err = (ph == P_LEAD) ? ERR_T1_INVALID
                            : (ph == P_T1SP ? ERR_T2_INVALID : ERR_T3_INVALID);
                    else begin
                        n.tlen = 1;
                        n.ph = phase_t'(ph + 1);
                        role = (ph == P_LEAD) ? ROLE_FIRST
                             : (ph == P_T1SP ? ROLE_SECOND : ROLE_THIRD);
                    end
                end
            end
            P_T1, P_T2: begin
                if (is_sp(c)) n.ph = phase_t'(ph + 1);
                else if (!is_text(c)) err = (ph == P_T1) ? ERR_T1_INVALID : ERR_T2_INVALID;
                else if (ph == P_T1) begin
                    err = token_char(n, lim[0], ERR_T1_LONG);
                    role = ROLE_FIRST;
                end else begin
                    err = token_char(n, lim[1], ERR_T2_LONG);
                    role = ROLE_SECOND;
                end
            end
            P_T3: begin
                if (c == CH_CR) n.ph = P_L1LF;
                else if (!is_text(c)) err = ERR_T3_INVALID;
                else begin
                    err = token_char(n, lim[2], ERR_T3_LONG);
                    role = ROLE_THIRD;
                end
            end
            P_L1LF: begin
                if (c != CH_LF) err = ERR_L1_LF;
                else n.ph = P_HDR;
            end
            P_HDR, P_NAME, P_VAL, P_VALLF, P_LWS:
                err = header_step(n, c, int'(ph) - int'(P_HDR), 1'b0, role);
            P_THDR, P_TNAME, P_TVAL, P_TVALLF, P_TLWS:
                err = header_step(n, c, int'(ph) - int'(P_THDR), 1'b1, role);
            P_ENDH, P_IBODY, P_CSIZE, P_CEXT, P_CSLF, P_CHUNK, P_CCR, P_CLF, P_FINLF:
                err = body_step(n, c);
            default: begin
                // Message start: the first byte clears everything left by the last one.
                if (is_sp(c)) begin
                    n = fresh_state();
                    n.ph = P_LEAD;
                end else if (is_text(c)) begin
                    n = fresh_state();
                    n.tlen = 1;
                    n.ph = P_T1;
                    role = ROLE_FIRST;
                end else err = ERR_T1_INVALID;
            end
        endcase

        r.echo = c;
        if (err >= 0) begin
            r.role = ROLE_DELIM;
            r.done = (ps.ph == P_MSG);
            r.perr = 1'b1;
            r.code = err[4:0];
            r.pos = ps.off[31:0];
            r.line = ps.lno[31:0];
            r.col = ps.col[31:0];
            return r;
        end
        n.off = (n.off + 1) & COUNT_MAX;
        if (c == CH_LF) begin
            n.lno = (n.lno + 1) & COUNT_MAX;
            n.col = 1;
        end else n.col = (n.col + 1) & COUNT_MAX;
        ps = n;
        r.role = role;
        r.done = (n.ph == P_MSG);
        r.perr = 1'b0;
        r.code = '0;
        r.pos = '0;
        r.line = '0;
        r.col = '0;
        return r;
    endfunction

    function automatic string show(byte_result_t r);
        return $sformatf("echo=%02h role=%0d done=%0b err=%0b code=%0d pos=%0d line=%0d col=%0d",
                         r.echo, r.role, r.done, r.perr, r.code, r.pos, r.line, r.col);
    endfunction

    initial begin
        error_count = 0;
        pending = 0;
        fails = 0;
    end

    always @(posedge aclk) begin
        byte_result_t want, got;
        if (!aresetn) begin
            ps = fresh_state();
            lim = '{16, 2048, 16, 256, 4096, 64};
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_byte_echo, m_byte_role, m_message_done, m_parse_error, m_error_code,
                        m_error_position, m_error_line, m_error_column};
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result word with nothing expected: %s", $time, show(got));
                end else begin
                    want = expected_results.pop_front();
                    if (want !== got) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: mismatch\n  expected %s\n  actual   %s",
                                     $time, show(want), show(got));
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_FIRST_LIMIT:  lim[0] = cfg_data;
                    REG_SECOND_LIMIT: lim[1] = cfg_data;
                    REG_THIRD_LIMIT:  lim[2] = cfg_data;
                    REG_NAME_LIMIT:   lim[3] = cfg_data;
                    REG_VALUE_LIMIT:  lim[4] = cfg_data;
                    REG_COUNT_LIMIT:  lim[5] = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_byte(s_data_byte));
        end
        pending <= expected_results.size();
        error_count <= fails;
    end

endmodule

/* bench/http_message_byte_parser_top_tb.sv */
`timescale 1ns / 1ps
module http_message_byte_parser_top_tb;
    import hmbp_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 225;
    localparam int HOLD_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_byte_echo;
    logic [2:0]  m_byte_role;
    logic        m_message_done;
    logic        m_parse_error;
    logic [4:0]  m_error_code;
    logic [31:0] m_error_position;
    logic [31:0] m_error_line;
    logic [31:0] m_error_column;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_FIRST_LIMIT;
    logic [12:0] cfg_data = 13'd0;

    int error_count;
    int pending;

    int send_idle = 0;
    int recv_stall = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    int hold_left = 0;
    int stall_cycles = 0;

    int lim_first = 16, lim_second = 2048, lim_third = 16;
    int lim_name = 256, lim_value = 4096, lim_count = 64;

    logic [7:0] msg_bytes [$];
    string name_chars =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!#$%&'*+-.^_`|~";

    always #4 aclk = ~aclk;

    http_message_byte_parser_top dut (.*);

    http_byte_checker u_check (.*);

    // Receiver: random stalls, plus one long hold-off that lets the pipeline fill.
    always @(negedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles == STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic int cap(int lim, int hi);
        return lim < hi ? lim : hi;
    endfunction

    // Mostly within the limit (capped at hi), now and then one byte longer, which can pass it.
    function automatic int pick_len(int lim, int hi);
        int n;
        n = $urandom_range(1, cap(lim, hi));
        if ($urandom_range(9) == 0) n++;
        return n;
    endfunction

    function automatic string mixed(string s);
        for (int i = 0; i < s.len(); i++)
            if (s[i] >= "a" && s[i] <= "z" && $urandom_range(1)) s[i] = s[i] - 8'd32;
        return s;
    endfunction

    // A control byte is rejected wherever it is placed by put.
    task automatic put(logic [7:0] c);
        int j;
        if ($urandom_range(99) < 5) begin
            j = $urandom_range(0, 31);
            if (j == 9 || j == 10 || j == 13) j = 127;
            msg_bytes.push_back(j[7:0]);
        end
        msg_bytes.push_back(c);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endtask

    task automatic put_value(int n);
        for (int i = 0; i < n; i++)
            if ($urandom_range(3) == 0) put(8'($urandom_range(128, 255)));
            else put(8'($urandom_range(32, 126)));
    endtask

    task automatic put_random_header();
        int n;
        n = pick_len(lim_name, 8);
        for (int i = 0; i < n; i++) put(name_chars[$urandom_range(0, name_chars.len() - 1)]);
        put(CH_COLON);
        put_value($urandom_range(0, cap(lim_value, 10)));
        put(CH_CR);
        put(CH_LF);
        if (lim_value >= 30 && $urandom_range(4) == 0) begin
            put($urandom_range(1) ? CH_SPACE : CH_TAB);
            put_value($urandom_range(1, 8));
            put(CH_CR);
            put(CH_LF);
        end
    endtask

    task automatic put_header(string name, string value);
        put_text(mixed(name));
        put(CH_COLON);
        put_text(value);
        put(CH_CR);
        put(CH_LF);
    endtask

    task automatic gen_message();
        int budget, mode, need, blen, n, sz;
        string v;
        budget = lim_count;
        if ($urandom_range(3) == 0) put(CH_SPACE);
        n = pick_len(lim_first, 6);
        for (int i = 0; i < n; i++) put(8'($urandom_range(33, 126)));
        put(CH_SPACE);
        n = pick_len(lim_second, 10);
        for (int i = 0; i < n; i++) put(8'($urandom_range(33, 126)));
        put(CH_SPACE);
        n = pick_len(lim_third, 10);
        put(8'($urandom_range(33, 126)));
        for (int i = 1; i < n; i++) put(8'($urandom_range(32, 126)));
        put(CH_CR);
        put(CH_LF);

        // 0 no framing header, 1 Content-Length, 2 chunked, 3 chunked beside a length
        mode = $urandom_range(0, 3);
        need = (mode == 0) ? 0 : (mode == 3 ? 2 : 1);
        if (need > budget || lim_name < 17 || lim_value < 12) begin
            mode = 0;
            need = 0;
        end
        n = $urandom_range(0, cap(budget - need, 2));
        budget -= n + need;
        repeat (n) put_random_header();
        blen = $urandom_range(0, 24);
        if (mode == 1 || mode == 3) begin
            v = $sformatf("%s%s%0d%s", $urandom_range(1) ? " " : "",
                          $urandom_range(3) == 0 ? "0" : "", blen,
                          $urandom_range(1) ? " " : "");
            if (mode == 3 && $urandom_range(1)) v = " 1x";
            put_header("content-length", v);
            if (mode == 1 && budget > 0 && $urandom_range(2) == 0) begin
                put_header("content-length", $sformatf(" %0d", blen + 7));
                budget--;
            end
        end
        if (mode >= 2)
            put_header("transfer-encoding", {$urandom_range(1) ? " " : "", mixed("chunked"),
                                             $urandom_range(1) ? " " : ""});
        if (mode == 0 && budget > 0 && $urandom_range(3) == 0) begin
            put_header("transfer-encoding", " gzip");
            budget--;
        end
        n = $urandom_range(0, cap(budget, 2));
        budget -= n;
        repeat (n) put_random_header();
        put(CH_CR);
        put(CH_LF);

        if (mode == 1) begin
            repeat (blen) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end else if (mode >= 2) begin
            repeat ($urandom_range(0, 3)) begin
                sz = $urandom_range(1, 20);
                v = mixed($sformatf("%s%0x", $urandom_range(3) == 0 ? "0" : "", sz));
                if ($urandom_range(9) == 0) put(";");
                put(v[0]);
                for (int i = 1; i < v.len(); i++) msg_bytes.push_back(v[i]);
                if ($urandom_range(3) == 0) begin
                    v = ";ext=1";
                    foreach (v[i]) msg_bytes.push_back(v[i]);
                end
                msg_bytes.push_back(CH_CR);
                put(CH_LF);
                repeat (sz) msg_bytes.push_back(8'($urandom_range(0, 255)));
                put(CH_CR);
                put(CH_LF);
            end
            put("0");
            msg_bytes.push_back(CH_CR);
            put(CH_LF);
            repeat ($urandom_range(0, cap(budget, 2))) put_random_header();
            put(CH_CR);
            put(CH_LF);
        end
    endtask

    task automatic send_byte(logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data_byte = b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_queued(inout int sent);
        while (msg_bytes.size() > 0) begin
            send_byte(msg_bytes.pop_front());
            sent++;
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val[12:0];
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic set_limits(int a, int b, int c, int d, int e, int f);
        lim_first = a;
        lim_second = b;
        lim_third = c;
        lim_name = d;
        lim_value = e;
        lim_count = f;
        write_reg(REG_FIRST_LIMIT, a);
        write_reg(REG_SECOND_LIMIT, b);
        write_reg(REG_THIRD_LIMIT, c);
        write_reg(REG_NAME_LIMIT, d);
        write_reg(REG_VALUE_LIMIT, e);
        write_reg(REG_COUNT_LIMIT, f);
    endtask

    task automatic run_phase(int idle_s, int idle_r);
        int sent;
        sent = 0;
        send_idle = idle_s;
        recv_stall = idle_r;
        while (sent < PHASE_ITEMS) begin
            gen_message();
            send_queued(sent);
        end
        wait_drained();
    endtask

    initial begin
        int sent;
        string s;
        sent = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Short directed message: bad bytes at message start, a leading blank,
        // a colon where a name should start, an empty-valued header, the blank line, then a DEL byte.
        msg_bytes = '{8'h00, 8'hFF, CH_TAB, "A", CH_SPACE, "/", CH_SPACE, "B", CH_CR, CH_LF,
                      CH_COLON, "n", CH_COLON, CH_CR, CH_LF, CH_CR, CH_LF, 8'h7F};
        send_queued(sent);
        run_phase(0, 0);

        set_limits(4096, 4096, 4096, 4096, 4096, 255);
        run_phase(66, 0);

        set_limits(1, 1, 1, 1, 1, 0);
        hold_req = 1;
        run_phase(0, 66);

        set_limits($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 12),
                   $urandom_range(1, 24), $urandom_range(1, 40), $urandom_range(0, 6));
        run_phase(23, 23);

        set_limits($urandom_range(1, 30), $urandom_range(1, 30), $urandom_range(1, 30),
                   $urandom_range(17, 40), $urandom_range(12, 60), $urandom_range(2, 8));
        run_phase(0, 0);

        set_limits(16, 2048, 16, 256, 4096, 64);
        run_phase(66, 23);

        // An oversized Content-Length leaves the parser waiting at the blank line for good,
        // so it comes last, followed by raw noise.
        s = "X Y Z\r\nContent-Length: 99999999999\r\n\r\n";
        foreach (s[i]) msg_bytes.push_back(s[i]);
        repeat (60) msg_bytes.push_back(8'($urandom_range(0, 255)));
        send_queued(sent);
        wait_drained();
        repeat (8) @(posedge aclk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
